// ===== hdl/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none

package spq_pkg;

  localparam int unsigned DEPTH = 8;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned VAL_W = 32;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_LIST   = 2'd2
  } command_e;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_OVERFLOW  = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_LISTED    = 3'd4
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    ins;
    logic    del;
    logic    single;
    status_e code;
    logic    list_clr;
    logic    list_emit;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic full;
    logic found;
    logic ptr_last;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== hdl/sorted_priority_queue_unit.sv =====
// Top level of the sorted priority queue: controller plus datapath.
// Depends on spq_pkg, spq_ctrl and spq_datapath.
//
//   Channel   Ports                                       Transfer
//   command   start, busy, command_i, item_value_i        start && !busy
//   result    valid_o, status_o, entry_value_o, last_o    every cycle valid_o is high
//
// Insert and delete results show in the cycle after the transfer.
// An unused code gives no result.
// A list keeps busy high while it streams its entries, one entry a cycle through
// the single read port on the entry array, the first entry passing the list state
// and then the result register; an empty list gives one result in the next cycle.
// Reset clears the entry count, the list state and the result strobe; the
// stored values need no clearing.
// The receiver cannot stall: every result is shown for exactly one cycle.
`default_nettype none

module sorted_priority_queue_unit (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [1:0]                       command_i,
  input  wire logic signed [spq_pkg::VAL_W-1:0] item_value_i,
  output logic                                  valid_o,
  output logic [2:0]                            status_o,
  output logic signed [spq_pkg::VAL_W-1:0]      entry_value_o,
  output logic                                  last_o
);

  spq_pkg::ctl_cmd_t ctl_cmd;
  spq_pkg::dp_stat_t dp_stat;

  spq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .command_i (command_i),
    .stat_i    (dp_stat),
    .cmd_o     (ctl_cmd),
    .busy      (busy)
  );

  spq_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_value_i  (item_value_i),
    .cmd_i         (ctl_cmd),
    .stat_o        (dp_stat),
    .valid_o       (valid_o),
    .status_o      (status_o),
    .entry_value_o (entry_value_o),
    .last_o        (last_o)
  );

endmodule

`default_nettype wire

// ===== hdl/spq_ctrl.sv =====
// Command controller of the sorted priority queue.
// Depends on spq_pkg; drives the datapath through spq_pkg::ctl_cmd_t.
`default_nettype none

module spq_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  input  wire logic [1:0]        command_i,
  input  wire spq_pkg::dp_stat_t stat_i,
  output spq_pkg::ctl_cmd_t      cmd_o,
  output logic                   busy
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LIST = 1'b1;

  logic state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.code    = spq_pkg::ST_DONE;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (command_i)
            spq_pkg::CMD_INSERT: begin
              cmd_o.single = 1'b1;
              if (stat_i.full) begin
                cmd_o.code = spq_pkg::ST_OVERFLOW;
              end else begin
                cmd_o.ins  = 1'b1;
                cmd_o.code = spq_pkg::ST_DONE;
              end
            end
            spq_pkg::CMD_DELETE: begin
              cmd_o.single = 1'b1;
              if (stat_i.empty) begin
                cmd_o.code = spq_pkg::ST_EMPTY;
              end else if (stat_i.found) begin
                cmd_o.del  = 1'b1;
                cmd_o.code = spq_pkg::ST_DONE;
              end else begin
                cmd_o.code = spq_pkg::ST_NOT_FOUND;
              end
            end
            spq_pkg::CMD_LIST: begin
              if (stat_i.empty) begin
                cmd_o.single = 1'b1;
                cmd_o.code   = spq_pkg::ST_EMPTY;
              end else begin
                cmd_o.list_clr = 1'b1;
                state_d        = S_LIST;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_LIST: begin
        cmd_o.list_emit = 1'b1;
        if (stat_i.ptr_last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q == S_LIST);

endmodule

`default_nettype wire

// ===== hdl/spq_datapath.sv =====
// Entry array, count, list pointer and result register of the queue.
// Depends on spq_pkg; takes commands from spq_ctrl and reports status back.
`default_nettype none

module spq_datapath (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic signed [spq_pkg::VAL_W-1:0]    item_value_i,
  input  wire spq_pkg::ctl_cmd_t                   cmd_i,
  output spq_pkg::dp_stat_t                        stat_o,
  output logic                                     valid_o,
  output logic [2:0]                               status_o,
  output logic signed [spq_pkg::VAL_W-1:0]         entry_value_o,
  output logic                                     last_o
);

  logic signed [spq_pkg::VAL_W-1:0] entries_q [spq_pkg::DEPTH];
  logic signed [spq_pkg::VAL_W-1:0] entries_d [spq_pkg::DEPTH];
  logic signed [spq_pkg::VAL_W-1:0] prev_v    [spq_pkg::DEPTH];
  logic signed [spq_pkg::VAL_W-1:0] next_v    [spq_pkg::DEPTH];
  logic [spq_pkg::CNT_W-1:0]        count_q, count_d;
  logic [spq_pkg::PTR_W-1:0]        ptr_q, ptr_d;
  logic [spq_pkg::DEPTH-1:0]        ins_mask;
  logic [spq_pkg::DEPTH-1:0]        eq_v;
  logic [spq_pkg::DEPTH-1:0]        del_mask;

  logic                             out_valid_q;
  logic [2:0]                       out_status_q;
  logic signed [spq_pkg::VAL_W-1:0] out_value_q;
  logic                             out_last_q;

  // Every cell compares against the incoming value at once. Since the array
  // is sorted, the insert mask is set from the insert position to the end,
  // and the delete mask from the first match to the end.
  always_comb begin
    for (int k = 0; k < spq_pkg::DEPTH; k++) begin
      if (spq_pkg::CNT_W'(k) < count_q) begin
        ins_mask[k] = (item_value_i >= entries_q[k]);
        eq_v[k]     = (item_value_i == entries_q[k]);
      end else begin
        ins_mask[k] = 1'b1;
        eq_v[k]     = 1'b0;
      end
    end
    del_mask[0] = eq_v[0];
    for (int k = 1; k < spq_pkg::DEPTH; k++) begin
      del_mask[k] = del_mask[k-1] | eq_v[k];
    end
    prev_v[0] = item_value_i;
    for (int k = 1; k < spq_pkg::DEPTH; k++) begin
      prev_v[k] = entries_q[k-1];
    end
    for (int k = 0; k < spq_pkg::DEPTH - 1; k++) begin
      next_v[k] = entries_q[k+1];
    end
    next_v[spq_pkg::DEPTH-1] = entries_q[spq_pkg::DEPTH-1];
  end

  always_comb begin
    for (int k = 0; k < spq_pkg::DEPTH; k++) begin
      entries_d[k] = entries_q[k];
      if (cmd_i.ins && ins_mask[k]) begin
        if (k > 0 && ins_mask[(k > 0) ? k - 1 : 0]) begin
          entries_d[k] = prev_v[k];
        end else begin
          entries_d[k] = item_value_i;
        end
      end else if (cmd_i.del && del_mask[k]) begin
        entries_d[k] = next_v[k];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.ins) begin
      count_d = count_q + spq_pkg::CNT_W'(1);
    end else if (cmd_i.del) begin
      count_d = count_q - spq_pkg::CNT_W'(1);
    end
    ptr_d = ptr_q;
    if (cmd_i.list_clr) begin
      ptr_d = '0;
    end else if (cmd_i.list_emit) begin
      ptr_d = ptr_q + spq_pkg::PTR_W'(1);
    end
  end

  assign stat_o.empty    = (count_q == '0);
  assign stat_o.full     = (count_q == spq_pkg::CNT_W'(spq_pkg::DEPTH));
  assign stat_o.found    = del_mask[spq_pkg::DEPTH-1];
  assign stat_o.ptr_last = (spq_pkg::CNT_W'(ptr_q) == (count_q - spq_pkg::CNT_W'(1)));

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < spq_pkg::DEPTH; k++) begin
      entries_q[k] <= entries_d[k];
    end
    if (cmd_i.single) begin
      out_status_q <= cmd_i.code;
      out_value_q  <= '0;
      out_last_q   <= 1'b1;
    end else if (cmd_i.list_emit) begin
      out_status_q <= spq_pkg::ST_LISTED;
      out_value_q  <= entries_q[ptr_q];
      out_last_q   <= stat_o.ptr_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      out_valid_q <= cmd_i.single | cmd_i.list_emit;
    end
  end

  assign valid_o       = out_valid_q;
  assign status_o      = out_status_q;
  assign entry_value_o = out_value_q;
  assign last_o        = out_last_q;

endmodule

`default_nettype wire

// ===== hdl/spq_checker.sv =====
// Port-level checks for sorted_priority_queue_unit, attached by bind.
// Depends on spq_pkg for the command and status codes.
`default_nettype none

module spq_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [1:0]  command_i,
  input wire logic        valid_o,
  input wire logic [2:0]  status_o,
  input wire logic        last_o
);

  // Every defined command yields a result; a non-empty list shows its first entry
  // after passing through the list state and the result register.
  a_cmd_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (command_i == spq_pkg::CMD_INSERT ||
    command_i == spq_pkg::CMD_DELETE || command_i == spq_pkg::CMD_LIST)
    |=> ##[0:1] valid_o)
    else $error("command transfer produced no result");

  // More listed entries are pending, so the block must still refuse commands.
  a_list_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_o |-> busy)
    else $error("list in progress but busy is low");

  // A list streams without gaps.
  a_list_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_o |=> valid_o)
    else $error("gap in list stream");

  // Only listed entries can be followed by more results.
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o != spq_pkg::ST_LISTED |-> last_o)
    else $error("status result without last marker");

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start     (start),
  .busy      (busy),
  .command_i (command_i),
  .valid_o   (valid_o),
  .status_o  (status_o),
  .last_o    (last_o)
);

`default_nettype wire

// ===== verif/sorted_priority_queue_unit_checker.sv =====
// Result checker for the sorted priority queue: watches both channels, keeps its
// own copy of the queue contents and compares every result transfer in order.
// Depends on spq_pkg for the command and status codes and the queue sizes.
`default_nettype none

module spq_result_checker
  import spq_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic                     busy_i,
  input  wire logic [1:0]               command_i,
  input  wire logic signed [VAL_W-1:0]  item_value_i,
  input  wire logic                     valid_i,
  input  wire logic [2:0]               status_i,
  input  wire logic signed [VAL_W-1:0]  entry_value_i,
  input  wire logic                     last_i,
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    status_e                 status;
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } queue_result_t;

  queue_result_t           pending_results[$];
  queue_result_t           oldest;
  logic signed [VAL_W-1:0] model_entries[DEPTH];
  int                      model_count = 0;
  int                      fail_count  = 0;
  int                      result_count = 0;

  function automatic queue_result_t make_result(status_e status,
                                                logic signed [VAL_W-1:0] value,
                                                logic last);
    queue_result_t r;
    r.status = status;
    r.value  = value;
    r.last   = last;
    return r;
  endfunction

  // Applies one accepted command to the shadow queue and queues up the
  // results the block has to produce for it.
  task automatic apply_queue_command(input logic [1:0] cmd,
                                     input logic signed [VAL_W-1:0] val);
    int k;
    int pos;
    bit hit;
    hit = 1'b0;
    pos = model_count;
    case (cmd)
      CMD_INSERT: begin
        if (model_count >= DEPTH) begin
          pending_results.push_back(make_result(ST_OVERFLOW, '0, 1'b1));
        end else begin
          // The new value goes in front of the first entry not above it.
          for (k = 0; k < model_count; k++) begin
            if (!hit && val >= model_entries[k]) begin
              pos = k;
              hit = 1'b1;
            end
          end
          for (k = model_count; k > pos; k--) begin
            model_entries[k] = model_entries[k-1];
          end
          model_entries[pos] = val;
          model_count++;
          pending_results.push_back(make_result(ST_DONE, '0, 1'b1));
        end
      end
      CMD_DELETE: begin
        if (model_count == 0) begin
          pending_results.push_back(make_result(ST_EMPTY, '0, 1'b1));
        end else begin
          for (k = 0; k < model_count; k++) begin
            if (!hit && model_entries[k] == val) begin
              pos = k;
              hit = 1'b1;
            end
          end
          if (hit) begin
            for (k = pos; k + 1 < model_count; k++) begin
              model_entries[k] = model_entries[k+1];
            end
            model_count--;
            pending_results.push_back(make_result(ST_DONE, '0, 1'b1));
          end else begin
            pending_results.push_back(make_result(ST_NOT_FOUND, '0, 1'b1));
          end
        end
      end
      CMD_LIST: begin
        if (model_count == 0) begin
          pending_results.push_back(make_result(ST_EMPTY, '0, 1'b1));
        end else begin
          for (k = 0; k < model_count; k++) begin
            pending_results.push_back(make_result(ST_LISTED, model_entries[k],
                                                  (k + 1 == model_count)));
          end
        end
      end
      default: begin
        // The spare command code is ignored.
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_results.delete();
      model_count = 0;
    end else begin
      // A result never shows in the cycle of its own command, so results are
      // checked before the command of this edge is predicted.
      if (valid_i) begin
        result_count++;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, actual status %0d value %0d last %0b",
                   $time, status_i, entry_value_i, last_i);
          fail_count++;
        end else begin
          oldest = pending_results.pop_front();
          if (status_i !== oldest.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, oldest.status, status_i);
            fail_count++;
          end
          if (entry_value_i !== oldest.value) begin
            $display("%0t: entry value mismatch, expected %0d, actual %0d",
                     $time, oldest.value, entry_value_i);
            fail_count++;
          end
          if (last_i !== oldest.last) begin
            $display("%0t: last mismatch, expected %0b, actual %0b",
                     $time, oldest.last, last_i);
            fail_count++;
          end
        end
      end
      if (start_i && !busy_i) begin
        apply_queue_command(command_i, item_value_i);
      end
    end
    fail_count_o <= fail_count;
    pending_o    <= pending_results.size();
    results_o    <= result_count;
  end

endmodule

`default_nettype wire

// ===== verif/sorted_priority_queue_unit_test.sv =====
// Top of the sorted priority queue testbench: clock, reset, command stimulus
// and the verdict. Depends on spq_pkg, the block and spq_result_checker.
`default_nettype none

module sorted_priority_queue_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import spq_pkg::*;

  localparam logic [1:0]              CMD_SPARE    = 2'd3;
  localparam int                      IDLE_PERCENT = 27;
  localparam int                      RANDOM_ITEMS = 128;
  localparam int                      POOL_SIZE    = 6;
  localparam int                      CYCLE_LIMIT  = 200000;
  localparam logic signed [VAL_W-1:0] MAX_VAL      = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] MIN_VAL      = {1'b1, {(VAL_W-1){1'b0}}};

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [1:0]               command_i = CMD_INSERT;
  logic signed [VAL_W-1:0]  item_value_i = '0;
  logic                     valid_o;
  logic [2:0]               status_o;
  logic signed [VAL_W-1:0]  entry_value_o;
  logic                     last_o;

  int                       fail_count;
  int                       pending;
  int                       results;
  int                       cycle_count = 0;
  int                       n_insert = 0;
  int                       n_delete = 0;
  int                       n_list = 0;
  int                       n_spare = 0;
  bit                       calm = 1'b0;
  logic signed [VAL_W-1:0]  value_pool[POOL_SIZE];

  sorted_priority_queue_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .command_i     (command_i),
    .item_value_i  (item_value_i),
    .valid_o       (valid_o),
    .status_o      (status_o),
    .entry_value_o (entry_value_o),
    .last_o        (last_o)
  );

  spq_result_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .command_i     (command_i),
    .item_value_i  (item_value_i),
    .valid_i       (valid_o),
    .status_i      (status_o),
    .entry_value_i (entry_value_o),
    .last_i        (last_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .results_o     (results)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results still outstanding", $time, pending);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Idles a random number of cycles, then holds the command until its transfer.
  // Junk is put on the fields while start is low.
  task automatic send_command(input logic [1:0] cmd, input logic signed [VAL_W-1:0] val);
    while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
      start        <= 1'b0;
      command_i    <= 2'($urandom_range(3));
      item_value_i <= $urandom;
      @(posedge clk_i);
    end
    start        <= 1'b1;
    command_i    <= cmd;
    item_value_i <= val;
    do @(posedge clk_i); while (busy);
    case (cmd)
      CMD_INSERT: n_insert++;
      CMD_DELETE: n_delete++;
      CMD_LIST:   n_list++;
      default:    n_spare++;
    endcase
  endtask

  // Mostly values from a small pool, so deletes hit and duplicates pile up.
  function automatic logic signed [VAL_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(99);
    if (roll < 60) begin
      return value_pool[$urandom_range(POOL_SIZE-1)];
    end else if (roll < 85) begin
      return $urandom;
    end
    case ($urandom_range(3))
      0:       return MAX_VAL;
      1:       return MIN_VAL;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  initial begin
    int n;
    int k;
    int mode;
    int roll;
    logic [1:0] cmd;

    mode = 2;
    for (k = 0; k < POOL_SIZE; k++) begin
      value_pool[k] = (k < 4) ? $signed($urandom_range(6)) - 3 : $signed($urandom);
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty cases, extremes, duplicates, a full queue.
    send_command(CMD_LIST,   '0);
    send_command(CMD_DELETE, 5);
    send_command(CMD_SPARE,  7);
    send_command(CMD_INSERT, '0);
    send_command(CMD_INSERT, MAX_VAL);
    send_command(CMD_INSERT, MIN_VAL);
    send_command(CMD_INSERT, '1);
    send_command(CMD_INSERT, '0);
    send_command(CMD_INSERT, 1);
    send_command(CMD_INSERT, MAX_VAL);
    send_command(CMD_INSERT, MIN_VAL);
    send_command(CMD_INSERT, 42);
    send_command(CMD_LIST,   '1);
    send_command(CMD_DELETE, 7);
    send_command(CMD_DELETE, MAX_VAL);
    send_command(CMD_DELETE, MIN_VAL);
    send_command(CMD_DELETE, '0);
    send_command(CMD_LIST,   '0);
    send_command(CMD_INSERT, 32'shAAAAAAAA);
    send_command(CMD_INSERT, 32'sh55555555);
    send_command(CMD_DELETE, 1);
    send_command(CMD_LIST,   '0);

    // Random part in phases that fill, drain or mix, with one stretch
    // where the sender never idles.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 60 && n < 100);
      if (n % 20 == 0) begin
        mode = $urandom_range(2);
      end
      if (n % 30 == 29) begin
        value_pool[$urandom_range(POOL_SIZE-1)] = $urandom;
      end
      roll = $urandom_range(99);
      case (mode)
        0:       cmd = (roll < 65) ? CMD_INSERT : (roll < 80) ? CMD_DELETE :
                       (roll < 96) ? CMD_LIST : CMD_SPARE;
        1:       cmd = (roll < 20) ? CMD_INSERT : (roll < 75) ? CMD_DELETE :
                       (roll < 96) ? CMD_LIST : CMD_SPARE;
        default: cmd = (roll < 40) ? CMD_INSERT : (roll < 75) ? CMD_DELETE :
                       (roll < 96) ? CMD_LIST : CMD_SPARE;
      endcase
      send_command(cmd, pick_value());
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (2 * DEPTH) @(posedge clk_i);

    $display("Covered %0d inserts, %0d deletes, %0d lists and %0d spare codes,",
             n_insert, n_delete, n_list, n_spare);
    $display("with %0d results checked against the shadow queue.", results);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
hdl/spq_pkg.sv
hdl/spq_ctrl.sv
hdl/spq_datapath.sv
hdl/sorted_priority_queue_unit.sv
hdl/spq_checker.sv
verif/sorted_priority_queue_unit_checker.sv
verif/sorted_priority_queue_unit_test.sv
